[hw/rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared item types, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned CapacityDefault = 32;
  localparam int unsigned IdxW            = 6;   // covers up to 64 cells
  localparam int unsigned DataW           = 32;

  localparam logic [2:0] CmdInsert = 3'd0;
  localparam logic [2:0] CmdDelete = 3'd1;
  localparam logic [2:0] CmdUpdate = 3'd2;
  localparam logic [2:0] CmdClear  = 3'd3;
  localparam logic [2:0] CmdDump   = 3'd4;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;
  localparam logic [1:0] StatusEmpty    = 2'd3;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [7:0]              position;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [5:0]              entry_position;
    logic signed [DataW-1:0] entry_value;
    logic [5:0]              list_length;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_INS  = 3'd1,
    OP_DEL  = 3'd2,
    OP_UPD  = 3'd3,
    OP_ROT  = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [IdxW-1:0]   idx;       // target cell of insert, delete or update
    logic [IdxW-1:0]   last_idx;  // tail cell of the rotation during dump
    logic [DataW-1:0]  wdata;     // write value, or head value on rotate
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

endpackage

[hw/rtl/positional_list_engine_top.sv]
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Results: insert, delete, update, clear and empty-dump results are registered
//   and offered in the cycle after their command transfer; a dump first enters
//   the dump state, which then registers one entry per cycle while the result side accepts.
// Throughput: one insert, delete, update or clear per cycle while the result
//   side accepts, since all cells shift in parallel; no command is taken during
//   a dump, and the row rotates one entry past the head per entry.
// Reset: clears the entry count, the sequencer and the output valid flag; the
//   cells are not reset and need no clearing pass.
module positional_list_engine_top import ple_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = 9;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  dump_k_q, dump_k_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  cell_ctrl_t       ctrl;
  logic [DataW-1:0] cell_val [CAPACITY];
  logic [DataW-1:0] rd_val;

  logic             slot_free;
  logic             in_fire;
  logic [CmpW-1:0]  pos_w;
  logic [CmpW-1:0]  cnt_w;
  logic [CmpW-1:0]  ins_pos;
  logic [IdxW-1:0]  pos_idx;
  logic             pos_hit;
  logic             full;
  logic             dump_last;

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
    logic [DataW-1:0] left;
    logic [DataW-1:0] right;
    if (c == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[c-1];
    end
    if (c == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_val[c+1];
    end
    ple_cell #(
      .MY_IDX (c)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .val_o   (cell_val[c])
    );
  end

  // value of the entry about to be removed
  always_comb begin
    rd_val = '0;
    for (int c = 0; c < CAPACITY; c++) begin
      rd_val = rd_val | (cell_val[c] & {DataW{IdxW'(c) == pos_idx}});
    end
  end

  // --------------------------------------------------------------------------
  // Command decode and sequencing
  // --------------------------------------------------------------------------
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_w     = CmpW'(in_item_i.position);
  assign cnt_w     = CmpW'(cnt_q);
  assign pos_idx   = IdxW'(pos_w - CmpW'(1));
  assign full      = (cnt_q == CntW'(CAPACITY));
  assign pos_hit   = (pos_w != '0) && (pos_w <= cnt_w);
  assign dump_last = (dump_k_q == CntW'(cnt_q - 1'b1));

  // clamp insert position to the head or one past the tail
  always_comb begin
    ins_pos = (pos_w == '0) ? CmpW'(1) : pos_w;
    if (ins_pos > cnt_w) begin
      ins_pos = cnt_w + CmpW'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dump_k_d    = dump_k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;

    ctrl.op       = OP_HOLD;
    ctrl.idx      = pos_idx;
    ctrl.last_idx = IdxW'(cnt_q - 1'b1);
    ctrl.wdata    = in_item_i.value;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_item_d.status         = StatusOk;
          out_item_d.entry_position = '0;
          out_item_d.entry_value    = '0;
          out_item_d.last           = 1'b1;
          out_valid_d               = 1'b1;
          case (in_item_i.cmd)
            CmdInsert: begin
              if (full) begin
                out_item_d.status = StatusFull;
              end else begin
                ctrl.op                   = OP_INS;
                ctrl.idx                  = IdxW'(ins_pos - CmpW'(1));
                cnt_d                     = cnt_q + 1'b1;
                out_item_d.entry_position = 6'(ins_pos);
                out_item_d.entry_value    = in_item_i.value;
              end
            end
            CmdDelete: begin
              if (!pos_hit) begin
                out_item_d.status = StatusNotFound;
              end else begin
                ctrl.op                   = OP_DEL;
                cnt_d                     = cnt_q - 1'b1;
                out_item_d.entry_position = 6'(pos_w);
                out_item_d.entry_value    = rd_val;
              end
            end
            CmdUpdate: begin
              if (!pos_hit) begin
                out_item_d.status = StatusNotFound;
              end else begin
                ctrl.op                   = OP_UPD;
                out_item_d.entry_position = 6'(pos_w);
                out_item_d.entry_value    = in_item_i.value;
              end
            end
            CmdClear: begin
              cnt_d = '0;
            end
            CmdDump: begin
              if (cnt_q == '0) begin
                out_item_d.status = StatusEmpty;
              end else begin
                // hold the result slot; entries follow from the dump state
                out_valid_d = out_valid_q && !out_ready_i;
                out_item_d  = out_item_q;
                state_d     = ST_DUMP;
                dump_k_d    = '0;
              end
            end
            default: begin
              // drop unused codes without a result
              out_valid_d = out_valid_q && !out_ready_i;
              out_item_d  = out_item_q;
            end
          endcase
          if (out_valid_d && (out_item_d != out_item_q || !out_valid_q || out_ready_i)) begin
            out_item_d.list_length = 6'(cnt_d);
          end
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          ctrl.op                   = OP_ROT;
          ctrl.wdata                = cell_val[0];
          out_valid_d               = 1'b1;
          out_item_d.status         = StatusOk;
          out_item_d.entry_position = 6'(dump_k_q + 1'b1);
          out_item_d.entry_value    = cell_val[0];
          out_item_d.list_length    = 6'(cnt_q);
          out_item_d.last           = dump_last;
          dump_k_d                  = dump_k_q + 1'b1;
          if (dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dump_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dump_k_q    <= dump_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_cnt_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> (cnt_q == $past(cnt_q)))
    else $error("entry count changed during dump");

  a_dump_k_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (dump_k_q < cnt_q))
    else $error("dump index past the tail");

  a_dump_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (cnt_q != '0))
    else $error("dump running on an empty list");

endmodule

[hw/rtl/ple_cell.sv]
// ----------------------------------------------------------------------------
// Positional list cell
// One list entry; loads the broadcast value or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
  parameter int unsigned MY_IDX = 0
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DataW-1:0]  left_i,
  input  logic [DataW-1:0]  right_i,
  output logic [DataW-1:0]  val_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(MY_IDX);

  logic [DataW-1:0] val_q;
  logic [DataW-1:0] val_d;

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      OP_INS: begin
        if (MyIdx == ctrl_i.idx) begin
          val_d = ctrl_i.wdata;
        end else if (MyIdx > ctrl_i.idx) begin
          val_d = left_i;
        end
      end
      OP_DEL: begin
        if (MyIdx >= ctrl_i.idx) begin
          val_d = right_i;
        end
      end
      OP_UPD: begin
        if (MyIdx == ctrl_i.idx) begin
          val_d = ctrl_i.wdata;
        end
      end
      OP_ROT: begin
        // tail wraps to the head value, the rest advance toward the head
        if (MyIdx == ctrl_i.last_idx) begin
          val_d = ctrl_i.wdata;
        end else if (MyIdx < ctrl_i.last_idx) begin
          val_d = right_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[tb/positional_list_engine_top_tb.sv]
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, delete, update, clear and dump commands with random gaps on
// the command side and random stalls on the result side. A shadow copy of the
// list predicts every result, which is checked field by field on transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
  import ple_pkg::*;

  localparam int unsigned Capacity   = CapacityDefault;
  localparam int          CycleLimit = 200000;
  localparam int          DrainWait  = 10;

  // command codes the block accepts and drops
  localparam logic [2:0] CmdFirstUnused = 3'd5;
  localparam logic [2:0] CmdLastUnused  = 3'd7;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  cmd_item  = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_item_t out_item;

  // shadow list and the list reports still owed by the block
  logic [DataW-1:0] shadow_cells [Capacity];
  int               shadow_len;
  out_item_t        report_q [$];

  int errors     = 0;
  int cycles     = 0;
  bit idle_on    = 1'b1;
  int stall_left = 0;

  positional_list_engine_top #(
    .CAPACITY(Capacity)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (cmd_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Apply one accepted command to the shadow list and queue its reports.
  function automatic void apply_list_cmd(input in_item_t it);
    out_item_t r;
    int        pos;
    int        i;
    logic [DataW-1:0] old;
    r      = '0;
    r.last = 1'b1;
    pos    = int'(it.position);
    case (it.cmd)
      CmdInsert: begin
        if (shadow_len >= int'(Capacity)) begin
          r.status = StatusFull;
        end else begin
          if (pos == 0) pos = 1;
          if (pos > shadow_len) pos = shadow_len + 1;
          for (i = shadow_len; i >= pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[pos-1] = it.value;
          shadow_len++;
          r.status         = StatusOk;
          r.entry_position = 6'(pos);
          r.entry_value    = it.value;
        end
        r.list_length = 6'(shadow_len);
        report_q.push_back(r);
      end
      CmdDelete, CmdUpdate: begin
        if (pos == 0 || pos > shadow_len) begin
          r.status = StatusNotFound;
        end else if (it.cmd == CmdUpdate) begin
          shadow_cells[pos-1] = it.value;
          r.entry_position    = 6'(pos);
          r.entry_value       = it.value;
        end else begin
          old = shadow_cells[pos-1];
          for (i = pos; i < shadow_len; i++) shadow_cells[i-1] = shadow_cells[i];
          shadow_len--;
          r.entry_position = 6'(pos);
          r.entry_value    = old;
        end
        r.list_length = 6'(shadow_len);
        report_q.push_back(r);
      end
      CmdClear: begin
        shadow_len = 0;
        report_q.push_back(r);
      end
      CmdDump: begin
        if (shadow_len == 0) begin
          r.status = StatusEmpty;
          report_q.push_back(r);
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            r.status         = StatusOk;
            r.entry_position = 6'(i + 1);
            r.entry_value    = shadow_cells[i];
            r.list_length    = 6'(shadow_len);
            r.last           = (i + 1 == shadow_len);
            report_q.push_back(r);
          end
        end
      end
      default: ;  // unused codes: no state change, no report
    endcase
  endfunction

  // Offer one command and return at the edge of its transfer, valid still high.
  task automatic send_list_cmd(input logic [2:0] cmd, input logic [7:0] pos,
                               input logic [DataW-1:0] val);
    in_item_t it;
    it.cmd      = cmd;
    it.position = pos;
    it.value    = val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_list_cmd(it);
  endtask

  // Drop valid and wait until every owed report has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (report_q.size() != 0);
  endtask

  function automatic in_item_t pick_random_cmd();
    in_item_t it;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      it.cmd = CmdInsert;
    else if (roll < 65) it.cmd = CmdDelete;
    else if (roll < 82) it.cmd = CmdUpdate;
    else if (roll < 88) it.cmd = CmdDump;
    else if (roll < 92) it.cmd = CmdClear;
    else if (roll < 96) it.cmd = 3'($urandom_range(CmdFirstUnused, CmdLastUnused));
    else                it.cmd = 3'($urandom());
    if ($urandom_range(0, 4) != 0) it.position = 8'($urandom_range(0, shadow_len + 2));
    else                           it.position = 8'($urandom());
    it.value = $urandom();
    return it;
  endfunction

  // Result side: random stall bursts unless idling is switched off.
  always @(posedge clk) begin : drive_out_ready
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(1, 7);
    end
  end

  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        flag_error($sformatf("unexpected result %p", out_item));
      end else begin
        want = report_q.pop_front();
        compare_field("status", 32'(out_item.status), 32'(want.status));
        compare_field("entry_position", 32'(out_item.entry_position),
                      32'(want.entry_position));
        compare_field("entry_value", out_item.entry_value, want.entry_value);
        compare_field("list_length", 32'(out_item.list_length),
                      32'(want.list_length));
        compare_field("last", 32'(out_item.last), 32'(want.last));
      end
    end
  end

  task automatic test_directed();
    send_list_cmd(CmdDump,   8'd0,   32'h0);
    send_list_cmd(CmdDelete, 8'd0,   32'h0);
    send_list_cmd(CmdUpdate, 8'd1,   32'h1234_5678);
    send_list_cmd(CmdInsert, 8'd0,   32'h8000_0000);
    send_list_cmd(CmdInsert, 8'd255, 32'h7FFF_FFFF);
    send_list_cmd(CmdInsert, 8'd1,   32'hFFFF_FFFF);
    send_list_cmd(CmdInsert, 8'd2,   32'h0);
    send_list_cmd(CmdInsert, 8'd9,   32'h5555_5555);
    send_list_cmd(CmdUpdate, 8'd0,   32'h1);
    send_list_cmd(CmdUpdate, 8'd5,   32'hAAAA_AAAA);
    send_list_cmd(CmdUpdate, 8'd6,   32'h2);
    send_list_cmd(CmdDelete, 8'd6,   32'h0);
    send_list_cmd(CmdDump,   8'd0,   32'h0);
    send_list_cmd(CmdDelete, 8'd1,   32'h0);
    send_list_cmd(CmdDelete, 8'd4,   32'h0);
    send_list_cmd(CmdDelete, 8'd0,   32'h0);
    for (int c = CmdFirstUnused; c <= CmdLastUnused; c++)
      send_list_cmd(3'(c), 8'($urandom()), $urandom());
    send_list_cmd(CmdDump,   8'd0,   32'h0);
    send_list_cmd(CmdClear,  8'd0,   32'h0);
    send_list_cmd(CmdDump,   8'd0,   32'h0);
    send_list_cmd(CmdInsert, 8'd3,   32'hDEAD_BEEF);
  endtask

  // Grow to capacity with random placement, then hit every full-list edge.
  task automatic test_fill_to_capacity();
    send_list_cmd(CmdClear, 8'd0, 32'h0);
    while (shadow_len < int'(Capacity)) begin
      if ($urandom_range(0, 3) == 0) send_list_cmd(CmdInsert, 8'($urandom()), $urandom());
      else send_list_cmd(CmdInsert, 8'($urandom_range(0, shadow_len + 1)), $urandom());
    end
    send_list_cmd(CmdInsert, 8'($urandom()), $urandom());
    send_list_cmd(CmdInsert, 8'd0, $urandom());
    send_list_cmd(CmdUpdate, 8'(Capacity), $urandom());
    send_list_cmd(CmdUpdate, 8'(Capacity + 1), $urandom());
    send_list_cmd(CmdDelete, 8'(Capacity + 1), 32'h0);
    send_list_cmd(CmdDump, 8'd0, 32'h0);
  endtask

  // Let the block go quiet, then drain the list from random positions.
  task automatic test_drain();
    hold_until_drained();
    send_list_cmd(CmdDelete, 8'(Capacity), 32'h0);
    while (shadow_len > 0) begin
      if ($urandom_range(0, 4) == 0)
        send_list_cmd(CmdUpdate, 8'($urandom_range(1, shadow_len)), $urandom());
      else
        send_list_cmd(CmdDelete, 8'($urandom_range(1, shadow_len)), 32'h0);
    end
    send_list_cmd(CmdDelete, 8'd1, 32'h0);
    send_list_cmd(CmdDump, 8'd0, 32'h0);
  endtask

  task automatic test_random_mix(input int n);
    in_item_t it;
    int       sent;
    int       stretch;
    sent    = 0;
    stretch = -1;
    while (sent < n) begin
      // switch idling per stretch of items; none in the closing stretch
      if (sent >= n - 20) begin
        idle_on = 1'b0;
      end else if (sent / 25 != stretch) begin
        stretch = sent / 25;
        idle_on = ($urandom_range(0, 3) != 0);
      end
      it = pick_random_cmd();
      send_list_cmd(it.cmd, it.position, it.value);
      if (it.cmd <= CmdDump) sent++;
    end
  endtask

  initial begin
    shadow_len = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_to_capacity();
    test_drain();
    test_random_mix(30);

    hold_until_drained();
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
